// ----- rtl/core/ptcp_pkg.sv -----
// Shared types, widths and vector arithmetic for the triangle closest-point core.
package ptcp_pkg;

    localparam int PROD_W  = 169;
    localparam int DEN_W   = 136;
    localparam int NUM_W   = 102;
    localparam int QB      = 35;
    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = QB + 2;
    localparam int GEO_LAT = 5 + 3 * MUL_LAT;
    localparam int LAT     = GEO_LAT + DIV_LAT;

    localparam logic [1:0] REG_FACE = 2'd0;
    localparam logic [1:0] REG_E12  = 2'd1;
    localparam logic [1:0] REG_E20  = 2'd2;
    localparam logic [1:0] REG_E01  = 2'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } v32_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } v33_t;

    typedef struct packed {
        logic signed [66:0] x;
        logic signed [66:0] y;
        logic signed [66:0] z;
    } v67_t;

    typedef struct packed {
        logic signed [100:0] x;
        logic signed [100:0] y;
        logic signed [100:0] z;
    } v101_t;

    typedef struct packed {
        v32_t v0;
        v32_t v1;
        v32_t v2;
        v32_t p;
    } in_t;

    typedef struct packed {
        v33_t                e;
        logic signed [135:0] f;
        logic signed [67:0]  s;
        logic signed [67:0]  t;
        logic signed [67:0]  ee;
    } edge_t;

    typedef struct packed {
        v33_t               e;
        v33_t               pa;
        logic signed [67:0] s;
        logic signed [67:0] t;
        logic signed [67:0] ee;
    } bedge_t;

    typedef struct packed {
        in_t          v;
        v67_t         n;
        bedge_t [2:0] ed;
    } stb_t;

    typedef struct packed {
        stb_t                    b;
        logic signed [136:0]     nn;
        logic signed [NUM_W-1:0] fnum;
    } stc_t;

    typedef struct packed {
        in_t                   v;
        edge_t [2:0]           ed;
        v67_t                  n;
        logic signed [136:0]   nn;
        logic signed [NUM_W-1:0] fnum;
    } geo_t;

    typedef struct packed {
        v32_t                    res;
        logic                    proj;
        v32_t                    base;
        logic signed [NUM_W-1:0] num;
        v67_t                    dir;
        logic [DEN_W-1:0]        den;
        logic [1:0]              region;
        logic                    degen;
    } sel_t;

    typedef struct packed {
        v32_t       res;
        logic       proj;
        logic [1:0] region;
        logic       degen;
    } side_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        v32_t             base;
        side_t            side;
    } fwd_t;

    function automatic v33_t vsub32(v32_t a, v32_t b);
        v33_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic v67_t cross33(v33_t a, v33_t b);
        v67_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic logic signed [67:0] dot33(v33_t a, v33_t b);
        logic signed [67:0] r;
        r = a.x * b.x + a.y * b.y + a.z * b.z;
        return r;
    endfunction

endpackage

// ----- rtl/core/ptcp_geom.sv -----
// Geometry front end (edges, normal, edge-plane tests) with its limb multiplier and delay line.
module ptcp_geom
    import ptcp_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  in_t  vin,
    output geo_t geo
);

    in_t   a_in_reg;
    v33_t  a_e_reg [3];
    v33_t  a_pa_reg [3];

    stb_t  b_reg;
    stb_t  bd;
    stc_t  c_reg;
    stc_t  cd;
    v101_t c_c_reg [3];
    geo_t  d_reg;

    logic signed [32:0]  b_e_c   [3][3];
    logic signed [32:0]  b_pa2_c [3];
    logic signed [66:0]  b_n_c   [3];
    logic signed [32:0]  c_pa_c  [3][3];
    logic signed [100:0] c_c_c   [3][3];

    logic signed [133:0] nn_p [3];
    logic signed [99:0]  fn_p [3];
    logic signed [99:0]  cp_p [3][3];
    logic signed [99:0]  cm_p [3][3];
    logic signed [133:0] f_p  [3][3];

    // Edge k runs from a to b: edge 1-2, edge 2-0, edge 0-1.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_in_reg    <= vin;
            a_e_reg[0]  <= vsub32(vin.v2, vin.v1);
            a_e_reg[1]  <= vsub32(vin.v0, vin.v2);
            a_e_reg[2]  <= vsub32(vin.v1, vin.v0);
            a_pa_reg[0] <= vsub32(vin.p, vin.v1);
            a_pa_reg[1] <= vsub32(vin.p, vin.v2);
            a_pa_reg[2] <= vsub32(vin.p, vin.v0);
        end
    end

    // The end vertex of edge k is the start vertex of edge k+1.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg.v <= a_in_reg;
            b_reg.n <= cross33(a_e_reg[2], a_e_reg[0]);
            for (int k = 0; k < 3; k++)
            begin
                b_reg.ed[k].e  <= a_e_reg[k];
                b_reg.ed[k].pa <= a_pa_reg[k];
                b_reg.ed[k].ee <= dot33(a_e_reg[k], a_e_reg[k]);
                b_reg.ed[k].t  <= dot33(a_e_reg[k], a_pa_reg[k]);
                b_reg.ed[k].s  <= dot33(a_e_reg[k], a_pa_reg[(k + 1) % 3]);
            end
        end
    end

    always_comb
    begin
        b_n_c[0]   = b_reg.n.x;
        b_n_c[1]   = b_reg.n.y;
        b_n_c[2]   = b_reg.n.z;
        b_pa2_c[0] = b_reg.ed[2].pa.x;
        b_pa2_c[1] = b_reg.ed[2].pa.y;
        b_pa2_c[2] = b_reg.ed[2].pa.z;
        for (int k = 0; k < 3; k++)
        begin
            b_e_c[k][0]  = b_reg.ed[k].e.x;
            b_e_c[k][1]  = b_reg.ed[k].e.y;
            b_e_c[k][2]  = b_reg.ed[k].e.z;
            c_pa_c[k][0] = c_reg.b.ed[k].pa.x;
            c_pa_c[k][1] = c_reg.b.ed[k].pa.y;
            c_pa_c[k][2] = c_reg.b.ed[k].pa.z;
            c_c_c[k][0]  = c_c_reg[k].x;
            c_c_c[k][1]  = c_c_reg[k].y;
            c_c_c[k][2]  = c_c_reg[k].z;
        end
    end

    // Component i of a cross product is a[i+1]*b[i+2] - a[i+2]*b[i+1].
    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        ptcp_mul #(.AW(67), .BW(67)) u_nn (
            .clk (clk), .en (en), .a (b_n_c[i]), .b (b_n_c[i]), .p (nn_p[i])
        );
        ptcp_mul #(.AW(33), .BW(67)) u_fn (
            .clk (clk), .en (en), .a (b_pa2_c[i]), .b (b_n_c[i]), .p (fn_p[i])
        );
        for (genvar k = 0; k < 3; k++)
        begin : g_edge
            ptcp_mul #(.AW(33), .BW(67)) u_cp (
                .clk (clk), .en (en), .a (b_e_c[k][(i + 1) % 3]),
                .b (b_n_c[(i + 2) % 3]), .p (cp_p[k][i])
            );
            ptcp_mul #(.AW(33), .BW(67)) u_cm (
                .clk (clk), .en (en), .a (b_e_c[k][(i + 2) % 3]),
                .b (b_n_c[(i + 1) % 3]), .p (cm_p[k][i])
            );
            ptcp_mul #(.AW(33), .BW(101)) u_f (
                .clk (clk), .en (en), .a (c_pa_c[k][i]), .b (c_c_c[k][i]), .p (f_p[k][i])
            );
        end
    end

    ptcp_dly #(.W($bits(stb_t)), .N(MUL_LAT)) u_dly_b (
        .clk (clk),
        .en  (en),
        .d   (b_reg),
        .q   (bd)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg.b    <= bd;
            c_reg.nn   <= 137'(nn_p[0]) + 137'(nn_p[1]) + 137'(nn_p[2]);
            c_reg.fnum <= -(NUM_W'(fn_p[0]) + NUM_W'(fn_p[1]) + NUM_W'(fn_p[2]));
            for (int k = 0; k < 3; k++)
            begin
                c_c_reg[k].x <= 101'(cp_p[k][0]) - 101'(cm_p[k][0]);
                c_c_reg[k].y <= 101'(cp_p[k][1]) - 101'(cm_p[k][1]);
                c_c_reg[k].z <= 101'(cp_p[k][2]) - 101'(cm_p[k][2]);
            end
        end
    end

    ptcp_dly #(.W($bits(stc_t)), .N(MUL_LAT)) u_dly_c (
        .clk (clk),
        .en  (en),
        .d   (c_reg),
        .q   (cd)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg.v    <= cd.b.v;
            d_reg.n    <= cd.b.n;
            d_reg.nn   <= cd.nn;
            d_reg.fnum <= cd.fnum;
            for (int k = 0; k < 3; k++)
            begin
                d_reg.ed[k].e  <= cd.b.ed[k].e;
                d_reg.ed[k].f  <= 136'(f_p[k][0]) + 136'(f_p[k][1]) + 136'(f_p[k][2]);
                d_reg.ed[k].s  <= cd.b.ed[k].s;
                d_reg.ed[k].t  <= cd.b.ed[k].t;
                d_reg.ed[k].ee <= cd.b.ed[k].ee;
            end
        end
    end

    assign geo = d_reg;

endmodule

// Signed multiplier built from 33 by 33 bit limb products over three stages.
module ptcp_mul
    import ptcp_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 33
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA  = (AW + 31) / 32;
    localparam int NB  = (BW + 31) / 32;
    localparam int AXW = NA * 32;
    localparam int BXW = NB * 32;
    localparam int PW  = AW + BW;

    logic signed [AXW-1:0] ax;
    logic signed [BXW-1:0] bx;
    logic signed [65:0]    pp_reg [NA][NB];
    logic signed [PW-1:0]  row_next [NA];
    logic signed [PW-1:0]  row_reg [NA];
    logic signed [PW-1:0]  p_next;
    logic signed [PW-1:0]  p_reg;

    // Only the top limb carries the sign; the lower limbs are unsigned.
    function automatic logic signed [32:0] limb(logic [31:0] v, logic top);
        return top ? $signed({v[31], v}) : $signed({1'b0, v});
    endfunction

    assign ax = AXW'(a);
    assign bx = BXW'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= limb(ax[i*32 +: 32], i == NA - 1)
                                    * limb(bx[j*32 +: 32], j == NB - 1);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) <<< (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            p_next = p_next + row_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// Delay line that keeps side data in step with the multipliers.
module ptcp_dly
    import ptcp_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

// ----- rtl/core/ptcp_select.sv -----
// Region decision stage: picks the vertex answer or the projection operands.
module ptcp_select
    import ptcp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] thr,
    input  geo_t        geo,
    output sel_t        sel
);

    sel_t sel_next;
    sel_t sel_reg;

    always_comb
    begin
        v32_t               av [3];
        v32_t               bv [3];
        logic signed [67:0] thr_e;
        logic signed [136:0] thr_f;
        av[0] = geo.v.v1;
        av[1] = geo.v.v2;
        av[2] = geo.v.v0;
        bv[0] = geo.v.v2;
        bv[1] = geo.v.v0;
        bv[2] = geo.v.v1;
        thr_e = $signed({36'b0, thr, 16'b0});
        thr_f = $signed({73'b0, thr, 48'b0});

        sel_next.res    = geo.v.v0;
        sel_next.base   = geo.v.p;
        sel_next.num    = geo.fnum;
        sel_next.dir    = geo.n;
        sel_next.den    = geo.nn[DEN_W-1:0];
        sel_next.region = REG_FACE;
        if (geo.nn == 0 || geo.nn < thr_f)
        begin
            sel_next.proj  = 1'b0;
            sel_next.degen = 1'b1;
        end
        else
        begin
            sel_next.proj  = 1'b1;
            sel_next.degen = 1'b0;
        end

        // Walk backward so the first firing edge is the one that stays.
        for (int k = 2; k >= 0; k--)
        begin
            if (geo.ed[k].f > 0)
            begin
                sel_next.region = 2'(k + 1);
                sel_next.proj   = 1'b0;
                sel_next.degen  = 1'b0;
                if (geo.ed[k].s > 0)
                begin
                    sel_next.res = bv[k];
                end
                else if (geo.ed[k].t < 0)
                begin
                    sel_next.res = av[k];
                end
                else if (geo.ed[k].ee == 0 || geo.ed[k].ee < thr_e)
                begin
                    sel_next.res   = bv[k];
                    sel_next.degen = 1'b1;
                end
                else
                begin
                    sel_next.proj  = 1'b1;
                    sel_next.base  = av[k];
                    sel_next.num   = NUM_W'(geo.ed[k].t);
                    sel_next.dir.x = 67'(geo.ed[k].e.x);
                    sel_next.dir.y = 67'(geo.ed[k].e.y);
                    sel_next.dir.z = 67'(geo.ed[k].e.z);
                    sel_next.den   = {68'b0, geo.ed[k].ee};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg <= sel_next;
        end
    end

    assign sel = sel_reg;

endmodule

// ----- rtl/core/ptcp_div.sv -----
// Pipelined restoring divider for one coordinate: rounded quotient, offset and saturation.
module ptcp_div
    import ptcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [PROD_W-1:0] prod,
    input  logic [DEN_W-1:0]         den,
    input  logic signed [31:0]       base,
    output logic signed [31:0]       coord
);

    localparam int NP_W  = PROD_W + 2;
    localparam int DP_W  = DEN_W + 1;
    localparam int CMP_W = NP_W + 1;
    localparam int SUM_W = QB + 2;

    logic [NP_W-1:0]   rem_reg  [QB+1];
    logic [DP_W-1:0]   dp_reg   [QB+1];
    logic [QB-1:0]     q_reg    [QB+1];
    logic              ovf_reg  [QB+1];
    logic              neg_reg  [QB+1];
    logic signed [31:0] base_reg [QB+1];
    logic signed [31:0] coord_reg;

    logic [PROD_W-1:0] mag;
    logic [NP_W-1:0]   np;
    logic [DP_W-1:0]   dp;

    // Rounding to nearest with ties away from zero: (2|n| + d) / (2d).
    always_comb
    begin
        mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        np  = NP_W'({mag, 1'b0}) + NP_W'(den);
        dp  = {den, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= np;
            dp_reg[0]   <= dp;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= CMP_W'(np) >= {dp, QB'(0)};
            neg_reg[0]  <= prod[PROD_W-1];
            base_reg[0] <= base;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        localparam int B = QB - j;
        logic [CMP_W-1:0] sh;
        logic             ge;
        always_comb
        begin
            sh = CMP_W'(dp_reg[j-1]) << B;
            ge = CMP_W'(rem_reg[j-1]) >= sh;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? NP_W'(CMP_W'(rem_reg[j-1]) - sh) : rem_reg[j-1];
                q_reg[j]    <= q_reg[j-1] | (ge ? (QB'(1) << B) : QB'(0));
                dp_reg[j]   <= dp_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                base_reg[j] <= base_reg[j-1];
            end
        end
    end

    logic [QB-1:0]          q;
    logic signed [QB:0]     sq;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-32:0]      hi;
    logic signed [31:0]     coord_next;

    // A quotient past the 35-bit range saturates whatever the base is.
    always_comb
    begin
        q   = ovf_reg[QB] ? '1 : q_reg[QB];
        sq  = neg_reg[QB] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum = sq + base_reg[QB];
        hi  = sum[SUM_W-1:31];
        if (hi == '0 || hi == '1)
        begin
            coord_next = sum[31:0];
        end
        else
        begin
            coord_next = sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

// ----- rtl/core/point_triangle_closest_point_core.sv -----
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Each item passes geometry, selection and the limb multipliers, then the
// 37-stage divider, one quotient bit per step stage between entry and output.
// Reset clears all valid bits and sets the threshold register thr_reg to 1.
// Top level: stream ports, threshold register, geometry, selection, multiplier stage and dividers.
module point_triangle_closest_point_core
    import ptcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, query_x, query_y, query_z
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // near_x, near_y, near_z
    output logic [95:0]  m_tdata,
    // region, degenerate
    output logic [2:0]   m_tuser
);

    logic [15:0]    thr_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;

    in_t  vin;
    geo_t geo;
    sel_t sel;

    logic signed [PROD_W-1:0] f_prod [3];
    fwd_t                     f_in;
    fwd_t                     f_out;
    side_t                    side_reg [DIV_LAT];
    logic signed [31:0]       coord [3];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign vin.v0.x = s_tdata[31:0];
    assign vin.v0.y = s_tdata[63:32];
    assign vin.v0.z = s_tdata[95:64];
    assign vin.v1.x = s_tdata[127:96];
    assign vin.v1.y = s_tdata[159:128];
    assign vin.v1.z = s_tdata[191:160];
    assign vin.v2.x = s_tdata[223:192];
    assign vin.v2.y = s_tdata[255:224];
    assign vin.v2.z = s_tdata[287:256];
    assign vin.p.x  = s_tdata[319:288];
    assign vin.p.y  = s_tdata[351:320];
    assign vin.p.z  = s_tdata[383:352];

    ptcp_geom u_geom (
        .clk (clk),
        .en  (en),
        .vin (vin),
        .geo (geo)
    );

    ptcp_select u_select (
        .clk (clk),
        .en  (en),
        .thr (thr_reg),
        .geo (geo),
        .sel (sel)
    );

    ptcp_mul #(.AW(NUM_W), .BW(67)) u_mul_x (
        .clk (clk), .en (en), .a (sel.num), .b (sel.dir.x), .p (f_prod[0])
    );

    ptcp_mul #(.AW(NUM_W), .BW(67)) u_mul_y (
        .clk (clk), .en (en), .a (sel.num), .b (sel.dir.y), .p (f_prod[1])
    );

    ptcp_mul #(.AW(NUM_W), .BW(67)) u_mul_z (
        .clk (clk), .en (en), .a (sel.num), .b (sel.dir.z), .p (f_prod[2])
    );

    always_comb
    begin
        f_in.den         = sel.den;
        f_in.base        = sel.base;
        f_in.side.res    = sel.res;
        f_in.side.proj   = sel.proj;
        f_in.side.region = sel.region;
        f_in.side.degen  = sel.degen;
    end

    ptcp_dly #(.W($bits(fwd_t)), .N(MUL_LAT)) u_fwd (
        .clk (clk),
        .en  (en),
        .d   (f_in),
        .q   (f_out)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= f_out.side;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    ptcp_div u_div_x (
        .clk   (clk),
        .en    (en),
        .prod  (f_prod[0]),
        .den   (f_out.den),
        .base  (f_out.base.x),
        .coord (coord[0])
    );

    ptcp_div u_div_y (
        .clk   (clk),
        .en    (en),
        .prod  (f_prod[1]),
        .den   (f_out.den),
        .base  (f_out.base.y),
        .coord (coord[1])
    );

    ptcp_div u_div_z (
        .clk   (clk),
        .en    (en),
        .prod  (f_prod[2]),
        .den   (f_out.den),
        .base  (f_out.base.z),
        .coord (coord[2])
    );

    side_t out_side;
    assign out_side = side_reg[DIV_LAT-1];

    always_comb
    begin
        if (out_side.proj)
        begin
            m_tdata = {coord[2], coord[1], coord[0]};
        end
        else
        begin
            m_tdata = {out_side.res.z, out_side.res.y, out_side.res.x};
        end
        m_tuser = {out_side.degen, out_side.region};
    end

endmodule
